FILE: hw/rtl/multi_pin_pulse_width_capture_macros.svh
// Assertion helpers shared by the capture block.
`ifndef MULTI_PIN_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define MULTI_PIN_PULSE_WIDTH_CAPTURE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPWC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPWC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mpwc_pkg.sv
package mpwc_pkg;

   // Pin layout
   localparam int NUM_PORTS     = 3;
   localparam int PINS_PER_PORT = 8;
   localparam int TOTAL_PINS    = NUM_PORTS * PINS_PER_PORT;
   localparam int MASK_REGS     = 3;

   // Field widths
   localparam int MODE_W  = 1;
   localparam int PORT_W  = 2;
   localparam int LEVEL_W = 8;
   localparam int TS_W    = 32;
   localparam int PIN_W   = 5;
   localparam int WIDTH_W = 16;
   localparam int MASK_W  = 8;

   // Index widths
   localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int BIT_IDX_W  = (PINS_PER_PORT > 1) ? $clog2(PINS_PER_PORT) : 1;
   localparam int GOOD_IDX_W = (TOTAL_PINS > 1) ? $clog2(TOTAL_PINS) : 1;
   localparam int MASK_IDX_W = $clog2(MASK_REGS);

   // Request tdata layout, lowest field first
   localparam int REQ_PORT_LSB  = 0;
   localparam int REQ_LEVEL_LSB = REQ_PORT_LSB + PORT_W;
   localparam int REQ_TS_LSB    = REQ_LEVEL_LSB + LEVEL_W;
   localparam int REQ_PIN_LSB   = REQ_TS_LSB + TS_W;
   localparam int REQ_USED_W    = REQ_PIN_LSB + PIN_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout
   localparam int RSP_USED_W  = WIDTH_W + PIN_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Config port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_PORT0_MASK = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PORT1_MASK = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PORT2_MASK = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_WIDTH  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_WIDTH  = 3'd4;

   localparam logic [WIDTH_W-1:0] RESET_MIN_WIDTH = 16'd950;
   localparam logic [WIDTH_W-1:0] RESET_MAX_WIDTH = 16'd2050;

   // Item kinds carried in tuser
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b0;
   localparam logic [MODE_W-1:0] MODE_READ   = 1'b1;

   // Sample beat broadcast to the lanes; only the low stamp bits matter
   typedef struct packed {
      logic                  valid;
      logic [PORT_IDX_W-1:0] port;
      logic [WIDTH_W-1:0]    stamp;
   } sample_type;

   // Width read request into the merge stage
   typedef struct packed {
      logic                  valid;
      logic                  pin_ok;
      logic [PORT_IDX_W-1:0] port;
      logic [BIT_IDX_W-1:0]  bit_sel;
      logic [PIN_W-1:0]      pin;
   } rd_req_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic [PIN_W-1:0]   pin;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } rsp_item_type;

   // Port part of a pin number
   function automatic logic [PORT_IDX_W-1:0] pin_port(input logic [PIN_W-1:0] pin);
      logic [PORT_IDX_W-1:0] port;
      port = '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
         if (int'(pin) >= p * PINS_PER_PORT) port = PORT_IDX_W'(p);
      end
      return port;
   endfunction

   // Bit-in-port part of a pin number
   function automatic logic [BIT_IDX_W-1:0] pin_bit(input logic [PIN_W-1:0] pin);
      logic [BIT_IDX_W-1:0] bit_sel;
      bit_sel = '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
         if (int'(pin) >= p * PINS_PER_PORT)
            bit_sel = BIT_IDX_W'(int'(pin) - p * PINS_PER_PORT);
      end
      return bit_sel;
   endfunction

endpackage

FILE: hw/rtl/multi_pin_pulse_width_capture.sv
// Pulse width capture on three ports of eight pins. A sample beat (tuser 0)
// records rise/fall stamps for enabled pins that changed; a read beat
// (tuser 1) returns the pin's last width that fell strictly inside
// (min_width, max_width). The block takes one beat per cycle while
// req_tready is high: each pin position of a port has its own lane, and all
// eight lanes handle a sample in the cycle it is accepted. A read result
// passes lane select, then window check, and waits in a four-entry
// result queue; req_tready drops only when the queue plus the read in
// flight already fill it. Sample beats never produce a result. State is
// cleared by reset directly, with no clearing pass.
module multi_pin_pulse_width_capture import mpwc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // port_index, pin_levels, timestamp_us, pin_index
   input  logic [MODE_W-1:0]      req_tuser,  // mode
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // width_us, read_pin
   // config write port
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "multi_pin_pulse_width_capture_macros.svh"

   logic [MASK_W-1:0]  mask_ff [MASK_REGS];
   logic [MASK_W-1:0]  mask_in [MASK_REGS];
   logic [WIDTH_W-1:0] min_width_ff, min_width_in;
   logic [WIDTH_W-1:0] max_width_ff, max_width_in;

   logic [PORT_W-1:0]  req_port;
   logic [LEVEL_W-1:0] req_levels;
   logic [TS_W-1:0]    req_stamp;
   logic [PIN_W-1:0]   req_pin;
   logic               accept;
   logic               sample_beat;
   logic               port_ok;
   logic [MASK_W-1:0]  port_mask;
   sample_type         sample;
   rd_req_type         rd;
   logic [WIDTH_W-1:0] lane_width [PINS_PER_PORT];
   logic               s1_valid;
   rsp_item_type       push;
   rsp_payload_type    head;
   logic [RSP_CNT_W-1:0] q_count;
   logic [RSP_CNT_W-1:0] q_committed;
   logic               queue_fits;

   // Config registers
   always_comb begin
      mask_in      = mask_ff;
      min_width_in = min_width_ff;
      max_width_in = max_width_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PORT0_MASK: mask_in[0] = csr_wdata[MASK_W-1:0];
            CSR_PORT1_MASK: mask_in[1] = csr_wdata[MASK_W-1:0];
            CSR_PORT2_MASK: mask_in[2] = csr_wdata[MASK_W-1:0];
            CSR_MIN_WIDTH:  min_width_in = csr_wdata[WIDTH_W-1:0];
            CSR_MAX_WIDTH:  max_width_in = csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASK_REGS; i++) mask_ff[i] <= '0;
         min_width_ff <= RESET_MIN_WIDTH;
         max_width_ff <= RESET_MAX_WIDTH;
      end else begin
         mask_ff      <= mask_in;
         min_width_ff <= min_width_in;
         max_width_ff <= max_width_in;
      end
   end

   // Request decode
   always_comb begin
      req_port    = req_tdata[REQ_PORT_LSB +: PORT_W];
      req_levels  = req_tdata[REQ_LEVEL_LSB +: LEVEL_W];
      req_stamp   = req_tdata[REQ_TS_LSB +: TS_W];
      req_pin     = req_tdata[REQ_PIN_LSB +: PIN_W];
      accept      = req_tvalid && req_tready;
      sample_beat = accept && (req_tuser == MODE_SAMPLE);
      port_ok     = int'(req_port) < NUM_PORTS;
      port_mask   = (int'(req_port) < MASK_REGS) ? mask_ff[MASK_IDX_W'(req_port)] : '0;

      sample.valid = sample_beat && port_ok;
      sample.port  = PORT_IDX_W'(req_port);
      sample.stamp = req_stamp[WIDTH_W-1:0];

      rd.valid   = accept && (req_tuser == MODE_READ);
      rd.pin_ok  = int'(req_pin) < TOTAL_PINS;
      rd.port    = pin_port(req_pin);
      rd.bit_sel = pin_bit(req_pin);
      rd.pin     = req_pin;
   end

   // Room for every read in flight in the result queue
   assign q_committed = q_count + RSP_CNT_W'(s1_valid);
   assign req_tready  = q_committed < RSP_CNT_W'(RSP_DEPTH);
   assign queue_fits  = q_committed <= RSP_CNT_W'(RSP_DEPTH);

   // Lanes, one per pin position
   for (genvar b = 0; b < PINS_PER_PORT; b++) begin : g_lane
      mpwc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .sample   (sample),
         .level    (req_levels[b]),
         .enable   (port_mask[b]),
         .rd_port  (rd.port),
         .rd_width (lane_width[b])
      );
   end

   mpwc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .rd         (rd),
      .lane_width (lane_width),
      .min_width  (min_width_ff),
      .max_width  (max_width_ff),
      .s1_valid   (s1_valid),
      .push       (push)
   );

   mpwc_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .count      (q_count)
   );

   assign rsp_tdata = {RSP_PAD_W'(0), head.pin, head.width};

   // Checks
   `MPWC_ASSERT_IMP(a_queue_credit, clock, reset, 1'b1, queue_fits, "result queue overcommitted")
   `MPWC_ASSERT_NXT(a_read_in_flight, clock, reset, rd.valid, s1_valid, "read not in flight")
   `MPWC_ASSERT_NXT(a_sample_no_result, clock, reset, sample_beat, !s1_valid, "stray result")

endmodule

FILE: hw/rtl/mpwc_lane.sv
// One pin position of every port: edge detect and rise/fall stamps.
module mpwc_lane import mpwc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  sample_type            sample,
   input  logic                  level,
   input  logic                  enable,
   input  logic [PORT_IDX_W-1:0] rd_port,
   output logic [WIDTH_W-1:0]    rd_width
);

   logic               level_ff [NUM_PORTS];
   logic               level_in [NUM_PORTS];
   logic [WIDTH_W-1:0] rise_ff  [NUM_PORTS];
   logic [WIDTH_W-1:0] rise_in  [NUM_PORTS];
   logic [WIDTH_W-1:0] fall_ff  [NUM_PORTS];
   logic [WIDTH_W-1:0] fall_in  [NUM_PORTS];
   logic               changed;

   // Level is always tracked; stamps only on enabled edges
   always_comb begin
      level_in = level_ff;
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      changed  = 1'b0;
      if (sample.valid) begin
         changed = (level ^ level_ff[sample.port]) & enable;
         level_in[sample.port] = level;
         if (changed && level) rise_in[sample.port] = sample.stamp;
         if (changed && !level) fall_in[sample.port] = sample.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            level_ff[p] <= 1'b0;
            rise_ff[p]  <= '0;
            fall_ff[p]  <= '0;
         end
      end else begin
         level_ff <= level_in;
         rise_ff  <= rise_in;
         fall_ff  <= fall_in;
      end
   end

   // Width modulo 2^16 needs only the low stamp bits
   assign rd_width = fall_ff[rd_port] - rise_ff[rd_port];

endmodule

FILE: hw/rtl/mpwc_merge.sv
// Picks the lane of the read pin, then applies the width window.
module mpwc_merge import mpwc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  rd_req_type         rd,
   input  logic [WIDTH_W-1:0] lane_width [PINS_PER_PORT],
   input  logic [WIDTH_W-1:0] min_width,
   input  logic [WIDTH_W-1:0] max_width,
   output logic               s1_valid,
   output rsp_item_type       push
);

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_ok_ff, s1_ok_in;
   logic [PIN_W-1:0]   s1_pin_ff, s1_pin_in;
   logic [WIDTH_W-1:0] s1_width_ff, s1_width_in;
   logic [WIDTH_W-1:0] good_ff [TOTAL_PINS];
   logic [WIDTH_W-1:0] good_in [TOTAL_PINS];
   logic [GOOD_IDX_W-1:0] good_idx;
   logic               in_window;
   logic [WIDTH_W-1:0] good_old;

   // Stage 1: lane select
   always_comb begin
      s1_valid_in = rd.valid;
      s1_ok_in    = rd.pin_ok;
      s1_pin_in   = rd.pin;
      s1_width_in = lane_width[rd.bit_sel];
   end

   // Stage 2: window check and last good width update
   always_comb begin
      good_idx  = GOOD_IDX_W'(s1_pin_ff);
      in_window = (s1_width_ff > min_width) && (s1_width_ff < max_width);
      good_old  = s1_ok_ff ? good_ff[good_idx] : '0;
      good_in   = good_ff;
      if (s1_valid_ff && s1_ok_ff && in_window) good_in[good_idx] = s1_width_ff;
      push.valid      = s1_valid_ff;
      push.data.pin   = s1_pin_ff;
      push.data.width = !s1_ok_ff ? '0 : (in_window ? s1_width_ff : good_old);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < TOTAL_PINS; i++) good_ff[i] <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         good_ff     <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff    <= s1_ok_in;
      s1_pin_ff   <= s1_pin_in;
      s1_width_ff <= s1_width_in;
   end

   assign s1_valid = s1_valid_ff;

endmodule

FILE: hw/rtl/mpwc_rsp_queue.sv
// Small result queue between the pipeline and the rsp channel.
module mpwc_rsp_queue import mpwc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  rsp_item_type         push,
   input  logic                 pop_ready,
   output logic                 head_valid,
   output rsp_payload_type      head,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_payload_type      entries_ff [RSP_DEPTH];
   rsp_payload_type      entries_in [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   // Pointer and count update
   always_comb begin
      pop        = (count_ff != '0) && pop_ready;
      entries_in = entries_ff;
      if (push.valid) entries_in[wr_ptr_ff] = push.data;
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.valid);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.valid) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule
